FILE: src/qbr_pkg.sv
// Shared types, constants and codes for the quartic bisection root finder.
`timescale 1ns / 1ps

package qbr_pkg;

  localparam int WORD_BITS      = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int PROD_BITS      = 2 * WORD_BITS;
  localparam int SCALED_BITS    = PROD_BITS - FRACTION_BITS;
  localparam int STEP_BITS      = 6;
  localparam int TOL_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COEF_SEL_BITS  = 2;

  localparam logic [STEP_BITS-1:0] MAX_ITERATIONS = 6'd63;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FOURTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_THIRD     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_SECOND    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FIRST     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_CONSTANT  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_TOLERANCE = 3'd6;

  // Outcome codes.
  localparam logic [1:0] OUTCOME_NO_ROOT = 2'd0;
  localparam logic [1:0] OUTCOME_EXACT   = 2'd1;
  localparam logic [1:0] OUTCOME_LIMIT   = 2'd2;

  // Horner coefficient selects, in order of use after the leading term.
  localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_THIRD    = 2'd0;
  localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_SECOND   = 2'd1;
  localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_FIRST    = 2'd2;
  localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_CONSTANT = 2'd3;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] lower_bound;
    logic signed [WORD_BITS-1:0] upper_bound;
  } operands_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] root_estimate;
    logic [1:0]                  outcome;
    logic [STEP_BITS-1:0]        steps_taken;
  } result_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_fourth;
    logic signed [WORD_BITS-1:0] coef_third;
    logic signed [WORD_BITS-1:0] coef_second;
    logic signed [WORD_BITS-1:0] coef_first;
    logic signed [WORD_BITS-1:0] coef_constant;
    logic [STEP_BITS-1:0]        iteration_limit;
    logic [TOL_BITS-1:0]         zero_tolerance;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ADD,
    ST_JUDGE
  } state_t;

  typedef enum logic [1:0] {
    PH_LOWER,
    PH_UPPER,
    PH_MID
  } phase_t;

  typedef enum logic [1:0] {
    XS_LOWER,
    XS_UPPER,
    XS_MID
  } xsel_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_X,
    RS_MID
  } rootsel_t;

  typedef struct packed {
    logic                     load;
    logic                     setup;
    xsel_t                    xsel;
    logic                     mul;
    logic                     add;
    logic [COEF_SEL_BITS-1:0] coef_sel;
    logic                     save_lo_sign;
    logic                     bisect;
    logic                     finish;
    rootsel_t                 root_sel;
    logic [1:0]               outcome;
    logic [STEP_BITS-1:0]     steps;
  } dp_cmd_t;

  typedef struct packed {
    logic signs_agree;
    logic tol_hit;
  } dp_status_t;

endpackage

FILE: src/quartic_bisection_root_top.sv
// Top level of the quartic bisection root finder.
`timescale 1ns / 1ps

// Finds a root of c4*x^4 + c3*x^3 + c2*x^2 + c1*x + c0 on [lower, upper], signed Q16.16.
// Configuration: write cfg_data to register cfg_index while cfg_write is high; the
// coefficients, iteration limit and zero tolerance take effect on the next item.
// Write them only while the block is idle.
// Input: an operand beat is taken at a clock edge with start high and busy low.
// Output: done is high for one cycle with the result beat on the result port;
// the receiver cannot stall it, so it must take the beat in that cycle.
// Each polynomial evaluation uses one shared 32x32 multiplier and a saturating
// adder: a setup step, then a multiply step and an add step per Horner term,
// then a decision step. Both ends are evaluated first, then one midpoint per
// bisection step, up to the iteration limit. busy falls in the cycle in which
// done is high, so a new beat may be started then.
// Reset clears the controller and the result strobe and restores the register
// defaults; an item in flight is dropped.

module quartic_bisection_root_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  qbr_pkg::operands_t                  operands,
  output logic                                done,
  output qbr_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [qbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [qbr_pkg::WORD_BITS-1:0]       cfg_data
);
  import qbr_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  qbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qbr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .iteration_limit (cfg.iteration_limit),
    .status          (status),
    .busy            (busy),
    .cmd             (cmd)
  );

  qbr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .result   (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a beat in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_no_root_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUTCOME_NO_ROOT) |->
      (result.root_estimate == '0 && result.steps_taken == '0))
    else $error("no-root result with nonzero estimate or step count");

  a_exact_steps: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUTCOME_EXACT) |-> (result.steps_taken != '0))
    else $error("exact root reported without a midpoint evaluation");

endmodule

FILE: src/qbr_cfg.sv
// Configuration register file for the quartic bisection root finder.
`timescale 1ns / 1ps

module qbr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [qbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [qbr_pkg::WORD_BITS-1:0]       cfg_data,
  output qbr_pkg::cfg_t                       cfg
);
  import qbr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_fourth     <= '0;
      cfg.coef_third      <= '0;
      cfg.coef_second     <= '0;
      cfg.coef_first      <= '0;
      cfg.coef_constant   <= '0;
      cfg.iteration_limit <= STEP_BITS'(32);
      cfg.zero_tolerance  <= TOL_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_FOURTH:     cfg.coef_fourth     <= $signed(cfg_data);
        REG_COEF_THIRD:      cfg.coef_third      <= $signed(cfg_data);
        REG_COEF_SECOND:     cfg.coef_second     <= $signed(cfg_data);
        REG_COEF_FIRST:      cfg.coef_first      <= $signed(cfg_data);
        REG_COEF_CONSTANT:   cfg.coef_constant   <= $signed(cfg_data);
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[STEP_BITS-1:0];
        REG_ZERO_TOLERANCE:  cfg.zero_tolerance  <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/qbr_dp.sv
// Datapath: interval registers, shared Horner multiplier and adder, result register.
`timescale 1ns / 1ps

module qbr_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  qbr_pkg::cfg_t         cfg,
  input  qbr_pkg::operands_t    operands,
  input  qbr_pkg::dp_cmd_t      cmd,
  output qbr_pkg::dp_status_t   status,
  output logic                  done,
  output qbr_pkg::result_t      result
);
  import qbr_pkg::*;

  // Product scaled down by the fraction width, magnitude truncated toward zero,
  // then saturated to the word range.
  function automatic logic signed [WORD_BITS-1:0] scale_sat(
      input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0]   biased;
    logic signed [SCALED_BITS-1:0] q;
    biased = p + $signed({{(PROD_BITS-FRACTION_BITS){1'b0}}, {FRACTION_BITS{p[PROD_BITS-1]}}});
    q = SCALED_BITS'(biased >>> FRACTION_BITS);
    if (!q[SCALED_BITS-1] && (|q[SCALED_BITS-2:WORD_BITS-1])) begin
      return WORD_MAX;
    end else if (q[SCALED_BITS-1] && !(&q[SCALED_BITS-2:WORD_BITS-1])) begin
      return WORD_MIN;
    end
    return q[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [WORD_BITS-1:0] add_sat(
      input logic signed [WORD_BITS-1:0] a,
      input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  logic signed [WORD_BITS-1:0] lo;
  logic signed [WORD_BITS-1:0] hi;
  logic signed [WORD_BITS-1:0] x;
  logic signed [WORD_BITS-1:0] acc;
  logic signed [PROD_BITS-1:0] prod;
  logic                        slo_zero;
  logic                        slo_neg;

  logic signed [WORD_BITS:0]   mid_sum;
  logic signed [WORD_BITS-1:0] mid;
  logic signed [WORD_BITS-1:0] coef;
  logic [WORD_BITS-1:0]        acc_mag;
  logic                        acc_zero;
  logic signed [WORD_BITS-1:0] root_value;

  // Midpoint is floor((lo + hi) / 2) on a sum one bit wider than the word.
  assign mid_sum  = (WORD_BITS+1)'(lo) + (WORD_BITS+1)'(hi);
  assign mid      = mid_sum[WORD_BITS:1];
  assign acc_zero = (acc == '0);
  assign acc_mag  = acc[WORD_BITS-1] ? (~acc + 1'b1) : acc;

  assign status.signs_agree = !slo_zero && !acc_zero && (slo_neg == acc[WORD_BITS-1]);
  assign status.tol_hit     = acc_mag < {{(WORD_BITS-TOL_BITS){1'b0}}, cfg.zero_tolerance};

  always_comb begin
    unique case (cmd.coef_sel)
      COEF_SEL_THIRD:    coef = cfg.coef_third;
      COEF_SEL_SECOND:   coef = cfg.coef_second;
      COEF_SEL_FIRST:    coef = cfg.coef_first;
      COEF_SEL_CONSTANT: coef = cfg.coef_constant;
      default:           coef = cfg.coef_constant;
    endcase
  end

  always_comb begin
    unique case (cmd.root_sel)
      RS_ZERO: root_value = '0;
      RS_X:    root_value = x;
      RS_MID:  root_value = mid;
      default: root_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= operands.lower_bound;
      hi <= operands.upper_bound;
    end
    if (cmd.setup) begin
      unique case (cmd.xsel)
        XS_LOWER: x <= lo;
        XS_UPPER: x <= hi;
        XS_MID:   x <= mid;
        default:  x <= mid;
      endcase
      acc <= cfg.coef_fourth;
    end
    if (cmd.mul) begin
      prod <= PROD_BITS'(acc) * PROD_BITS'(x);
    end
    if (cmd.add) begin
      acc <= add_sat(scale_sat(prod), coef);
    end
    if (cmd.save_lo_sign) begin
      slo_zero <= acc_zero;
      slo_neg  <= acc[WORD_BITS-1];
    end
    // The interval keeps its lower half unless the midpoint has the sign of the lower end.
    if (cmd.bisect) begin
      if (!status.signs_agree) begin
        hi <= x;
      end else begin
        lo       <= x;
        slo_zero <= acc_zero;
        slo_neg  <= acc[WORD_BITS-1];
      end
    end
    if (cmd.finish) begin
      result.root_estimate <= root_value;
      result.outcome       <= cmd.outcome;
      result.steps_taken   <= cmd.steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

FILE: src/qbr_ctrl.sv
// Controller: sequences the end evaluations, the bisection steps and the result beat.
`timescale 1ns / 1ps

module qbr_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [qbr_pkg::STEP_BITS-1:0]   iteration_limit,
  input  qbr_pkg::dp_status_t             status,
  output logic                            busy,
  output qbr_pkg::dp_cmd_t                cmd
);
  import qbr_pkg::*;

  state_t                   state;
  state_t                   state_next;
  phase_t                   phase;
  phase_t                   phase_next;
  logic [COEF_SEL_BITS-1:0] term;
  logic [STEP_BITS-1:0]     iter;
  logic [STEP_BITS-1:0]     iter_next;
  logic [STEP_BITS-1:0]     iter_inc;
  logic [STEP_BITS-1:0]     limit;

  assign limit    = (iteration_limit > MAX_ITERATIONS) ? MAX_ITERATIONS : iteration_limit;
  assign iter_inc = iter + 1'b1;
  assign busy     = (state != ST_IDLE);

  // Next state, phase and iteration count.
  always_comb begin
    state_next = state;
    phase_next = phase;
    iter_next  = iter;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SETUP;
          phase_next = PH_LOWER;
        end
      end
      ST_SETUP: state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD: begin
        state_next = (term == COEF_SEL_CONSTANT) ? ST_JUDGE : ST_MUL;
      end
      ST_JUDGE: begin
        unique case (phase)
          PH_LOWER: begin
            state_next = ST_SETUP;
            phase_next = PH_UPPER;
          end
          PH_UPPER: begin
            if (status.signs_agree || limit == '0) begin
              state_next = ST_IDLE;
            end else begin
              state_next = ST_SETUP;
              phase_next = PH_MID;
              iter_next  = '0;
            end
          end
          PH_MID: begin
            if (status.tol_hit || iter_inc == limit) begin
              state_next = ST_IDLE;
            end else begin
              state_next = ST_SETUP;
              iter_next  = iter_inc;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    cmd.coef_sel = term;
    unique case (phase)
      PH_LOWER: cmd.xsel = XS_LOWER;
      PH_UPPER: cmd.xsel = XS_UPPER;
      PH_MID:   cmd.xsel = XS_MID;
      default:  cmd.xsel = XS_MID;
    endcase
    unique case (state)
      ST_IDLE:  cmd.load  = start;
      ST_SETUP: cmd.setup = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_ADD:   cmd.add   = 1'b1;
      ST_JUDGE: begin
        unique case (phase)
          PH_LOWER: cmd.save_lo_sign = 1'b1;
          PH_UPPER: begin
            if (status.signs_agree) begin
              cmd.finish   = 1'b1;
              cmd.root_sel = RS_ZERO;
              cmd.outcome  = OUTCOME_NO_ROOT;
              cmd.steps    = '0;
            end else if (limit == '0) begin
              cmd.finish   = 1'b1;
              cmd.root_sel = RS_MID;
              cmd.outcome  = OUTCOME_LIMIT;
              cmd.steps    = '0;
            end
          end
          PH_MID: begin
            if (status.tol_hit) begin
              cmd.finish   = 1'b1;
              cmd.root_sel = RS_X;
              cmd.outcome  = OUTCOME_EXACT;
              cmd.steps    = iter_inc;
            end else begin
              cmd.bisect = 1'b1;
              if (iter_inc == limit) begin
                cmd.finish   = 1'b1;
                cmd.root_sel = RS_X;
                cmd.outcome  = OUTCOME_LIMIT;
                cmd.steps    = limit;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_LOWER;
      iter  <= '0;
      term  <= COEF_SEL_THIRD;
    end else begin
      state <= state_next;
      phase <= phase_next;
      iter  <= iter_next;
      if (state == ST_SETUP) begin
        term <= COEF_SEL_THIRD;
      end else if (state == ST_ADD) begin
        term <= term + 1'b1;
      end
    end
  end

endmodule
